// File: rtl/core/edga_pkg.sv
`default_nettype none

package edga_pkg;

  localparam int NUM_TYPES_DEF = 8;
  localparam int NUM_ALPHA_DEF = 16;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ACC   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0] LN2_Q24   = 32'd11629080;
  localparam logic [25:0] ONE_Q24   = 26'd16777216;
  localparam logic [62:0] TERM_CAP  = 63'h4000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         type_index;
    logic [3:0]         alpha_index;
    logic signed [15:0] descriptor;
    logic signed [23:0] upstream_grad;
    logic signed [15:0] decay_param;
    logic signed [15:0] embed_weight;
  } edga_in_t;

  typedef struct packed {
    logic signed [47:0] grad_alpha_sum;
    logic signed [47:0] grad_embed_sum;
    logic               overflow;
  } edga_out_t;

  // floor(2^32 / n) for the Horner divisors
  function automatic logic [31:0] recip(input logic [2:0] n);
    logic [31:0] r;
    unique case (n)
      3'd2:    r = 32'd2147483648;
      3'd3:    r = 32'd1431655765;
      3'd4:    r = 32'd1073741824;
      3'd5:    r = 32'd858993459;
      3'd6:    r = 32'd715827882;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // rounded product shift, clamped to 2^62
  function automatic logic [62:0] mulsh(input logic [94:0] p, input logic sh12);
    logic [94:0] rp;
    rp = p + (sh12 ? 95'd2048 : 95'd128);
    if (p > {32'd0, TERM_CAP}) begin
      return TERM_CAP;
    end
    return sh12 ? rp[74:12] : rp[70:8];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/exp_descriptor_gradient_accumulator.sv
`default_nettype none

// Exponential-descriptor gradient accumulator.
// Input channel: a word on in_word is taken at a rising edge with start high
// and busy low. Commands: load a/w for a row, accumulate one term into a row,
// read a row, clear all accumulators and the overflow flag.
// Result channel: a read returns one word on out_word, marked by out_valid
// for exactly one cycle; out_valid and the word are registered from the read
// state, which follows the accepting edge. The receiver cannot stall.
// Busy: load leaves busy low. Read holds busy while in the read state.
// Accumulate holds busy until its write-back: two partial-product multipliers
// (low and high half of op_a) compute 19 products in two halves each, plus five
// divide corrections for the exponential's Horner steps, then a
// read-modify-write of the accumulator memory.
// Clear holds busy while it sweeps all NUM_TYPES*NUM_ALPHA rows, one memory row a cycle.
// Reset: after rst_n rises, the accumulator memory is swept to zero, all
// NUM_TYPES*NUM_ALPHA rows, with busy high. Parameter tables are not reset.
// Row index out of range: load and accumulate are dropped, read returns zero sums.
module exp_descriptor_gradient_accumulator #(
  parameter int NUM_TYPES = edga_pkg::NUM_TYPES_DEF,
  parameter int NUM_ALPHA = edga_pkg::NUM_ALPHA_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire edga_pkg::edga_in_t  in_word,
  output logic                     busy,
  output logic                     out_valid,
  output edga_pkg::edga_out_t      out_word
);

  import edga_pkg::*;

  localparam int ROWS = NUM_TYPES * NUM_ALPHA;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RCW  = 13;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_MLO   = 4'd4;
  localparam logic [3:0] S_MHI   = 4'd5;
  localparam logic [3:0] S_POST  = 4'd6;
  localparam logic [3:0] S_DIVC  = 4'd7;
  localparam logic [3:0] S_EXPF  = 4'd8;
  localparam logic [3:0] S_WB    = 4'd9;

  localparam logic [3:0] OP_AD = 4'd0;
  localparam logic [3:0] OP_Y  = 4'd1;
  localparam logic [3:0] OP_R  = 4'd2;
  localparam logic [3:0] OP_HV = 4'd3;
  localparam logic [3:0] OP_HQ = 4'd4;
  localparam logic [3:0] OP_Q  = 4'd5;
  localparam logic [3:0] OP_TE = 4'd6;
  localparam logic [3:0] OP_T1 = 4'd7;
  localparam logic [3:0] OP_T2 = 4'd8;
  localparam logic [3:0] OP_TA = 4'd9;

  logic [31:0] param_mem [ROWS];
  logic [95:0] acc_mem   [ROWS];

  logic [3:0]  state_r, state_nxt;
  logic [3:0]  op_r, op_nxt;
  logic [RW-1:0] clr_idx_r, clr_idx_nxt;
  logic        sat_r, sat_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [RW-1:0] row_r, row_nxt;
  logic        ok_r, ok_nxt;
  logic [15:0] dmag_r, dmag_nxt;
  logic [23:0] gmag_r, gmag_nxt;
  logic        dneg_r, dneg_nxt;
  logic        gneg_r, gneg_nxt;
  logic        xneg_r, xneg_nxt;
  logic [62:0] op_a_r, op_a_nxt;
  logic [31:0] op_b_r, op_b_nxt;
  logic [94:0] prod_r, prod_nxt;
  logic signed [7:0] k_r, k_nxt;
  logic [23:0] r_r, r_nxt;
  logic [25:0] p_r, p_nxt;
  logic [24:0] v_r, v_nxt;
  logic [24:0] q_r, q_nxt;
  logic [2:0]  n_r, n_nxt;
  logic [62:0] qv_r, qv_nxt;
  logic [62:0] te_r, te_nxt;
  logic [62:0] ta_r, ta_nxt;
  edga_out_t   out_word_r, out_word_nxt;
  logic [31:0] param_q_r;
  logic [95:0] acc_q_r;

  logic          accept, in_ok, rd_en, param_we, acc_we;
  logic [RCW-1:0] row_full;
  logic [RW-1:0] row_in, acc_waddr;
  logic [95:0]   acc_wdata;
  logic [15:0]   in_dmag, amag, wmag;
  logic [23:0]   in_gmag;
  logic [63:0]   pp_lo;
  logic [62:0]   pp_hi;
  logic [63:0]   ym, y54, yb;
  logic [31:0]   yq;
  logic [62:0]   msh12, msh8;
  logic [27:0]   qn, rem;
  logic [24:0]   qc;
  logic [8:0]    rsh;
  logic [31:0]   e_v;
  logic [64:0]   sum_a, sum_e;
  logic          ov_a, ov_e;
  logic [47:0]   sat_a, sat_e;

  assign accept   = start && !busy;
  assign in_ok    = (int'(in_word.type_index) < NUM_TYPES) &&
                    (int'(in_word.alpha_index) < NUM_ALPHA);
  assign row_full = RCW'(in_word.type_index) * RCW'(NUM_ALPHA) + RCW'(in_word.alpha_index);
  assign row_in   = row_full[RW-1:0];
  assign rd_en    = accept && in_ok;
  assign param_we = rd_en && (in_word.cmd == CMD_LOAD);

  assign in_dmag = in_word.descriptor[15] ? 16'(-in_word.descriptor) : in_word.descriptor;
  assign in_gmag = in_word.upstream_grad[23] ? 24'(-in_word.upstream_grad)
                                             : in_word.upstream_grad;
  assign amag    = param_q_r[31] ? 16'(-param_q_r[31:16]) : param_q_r[31:16];
  assign wmag    = param_q_r[15] ? 16'(-param_q_r[15:0]) : param_q_r[15:0];

  assign pp_lo = op_a_r[31:0] * op_b_r;
  assign pp_hi = op_a_r[62:32] * op_b_r;

  assign ym  = {2'd0, prod_r[61:0]};
  assign y54 = xneg_r ? 64'(-ym) : ym;
  assign yb  = y54 + 64'h2000_0000_0000_0000;
  assign yq  = yb[61:30];

  assign msh12 = mulsh(prod_r, 1'b1);
  assign msh8  = mulsh(prod_r, 1'b0);

  assign qn  = q_r * n_r;
  assign rem = {3'd0, v_r} - qn;
  assign qc  = (rem >= 28'(n_r)) ? q_r + 25'd1 : q_r;

  assign rsh = 9'd8 - 9'({k_r[7], k_r});
  always_comb begin
    if (k_r >= 8'sd16) begin
      e_v = 32'hFFFF_FFFF;
    end else if (k_r >= 8'sd8) begin
      e_v = 32'(p_r) << k_r[2:0];
    end else begin
      e_v = 32'(p_r >> rsh);
    end
  end

  assign sum_a = (param_q_r[15] ^ gneg_r) ?
                 {{17{acc_q_r[95]}}, acc_q_r[95:48]} - {2'd0, ta_r} :
                 {{17{acc_q_r[95]}}, acc_q_r[95:48]} + {2'd0, ta_r};
  assign sum_e = (dneg_r ^ gneg_r) ?
                 {{17{acc_q_r[47]}}, acc_q_r[47:0]} - {2'd0, te_r} :
                 {{17{acc_q_r[47]}}, acc_q_r[47:0]} + {2'd0, te_r};
  assign ov_a  = sum_a[64:47] != {18{sum_a[64]}};
  assign ov_e  = sum_e[64:47] != {18{sum_e[64]}};
  assign sat_a = ov_a ? (sum_a[64] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : sum_a[47:0];
  assign sat_e = ov_e ? (sum_e[64] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : sum_e[47:0];

  assign acc_we    = (state_r == S_CLEAR) || (state_r == S_WB);
  assign acc_waddr = (state_r == S_CLEAR) ? clr_idx_r : row_r;
  assign acc_wdata = (state_r == S_CLEAR) ? 96'd0 : {sat_a, sat_e};

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    clr_idx_nxt   = clr_idx_r;
    sat_nxt       = sat_r;
    out_valid_nxt = 1'b0;
    row_nxt       = row_r;
    ok_nxt        = ok_r;
    dmag_nxt      = dmag_r;
    gmag_nxt      = gmag_r;
    dneg_nxt      = dneg_r;
    gneg_nxt      = gneg_r;
    xneg_nxt      = xneg_r;
    op_a_nxt      = op_a_r;
    op_b_nxt      = op_b_r;
    prod_nxt      = prod_r;
    k_nxt         = k_r;
    r_nxt         = r_r;
    p_nxt         = p_r;
    v_nxt         = v_r;
    q_nxt         = q_r;
    n_nxt         = n_r;
    qv_nxt        = qv_r;
    te_nxt        = te_r;
    ta_nxt        = ta_r;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + RW'(1);
        if (clr_idx_r == RW'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          row_nxt  = row_in;
          ok_nxt   = in_ok;
          dmag_nxt = in_dmag;
          gmag_nxt = in_gmag;
          dneg_nxt = in_word.descriptor[15];
          gneg_nxt = in_word.upstream_grad[23];
          unique case (in_word.cmd)
            CMD_LOAD: begin
            end
            CMD_ACC: begin
              if (in_ok) begin
                state_nxt = S_SETUP;
              end
            end
            CMD_READ: begin
              state_nxt = S_READ;
            end
            CMD_CLEAR: begin
              sat_nxt     = 1'b0;
              clr_idx_nxt = '0;
              state_nxt   = S_CLEAR;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt               = 1'b1;
        out_word_nxt.grad_alpha_sum = ok_r ? acc_q_r[95:48] : 48'd0;
        out_word_nxt.grad_embed_sum = ok_r ? acc_q_r[47:0] : 48'd0;
        out_word_nxt.overflow       = sat_r;
        state_nxt                   = S_IDLE;
      end
      S_SETUP: begin
        op_a_nxt  = 63'(amag);
        op_b_nxt  = 32'(dmag_r);
        xneg_nxt  = param_q_r[31] ^ dneg_r;
        op_nxt    = OP_AD;
        state_nxt = S_MLO;
      end
      S_MLO: begin
        prod_nxt  = {31'd0, pp_lo};
        state_nxt = S_MHI;
      end
      S_MHI: begin
        prod_nxt  = prod_r + {pp_hi, 32'd0};
        state_nxt = S_POST;
      end
      S_POST: begin
        state_nxt = S_MLO;
        unique case (op_r)
          OP_AD: begin
            op_a_nxt = {32'd0, prod_r[30:0]};
            op_b_nxt = LOG2E_Q30;
            op_nxt   = OP_Y;
          end
          OP_Y: begin
            k_nxt    = {~yq[31], yq[30:24]};
            op_a_nxt = {39'd0, yq[23:0]};
            op_b_nxt = LN2_Q24;
            op_nxt   = OP_R;
          end
          OP_R: begin
            r_nxt    = prod_r[47:24];
            p_nxt    = ONE_Q24;
            n_nxt    = 3'd6;
            op_a_nxt = {39'd0, prod_r[47:24]};
            op_b_nxt = 32'(ONE_Q24);
            op_nxt   = OP_HV;
          end
          OP_HV: begin
            v_nxt = prod_r[48:24];
            if (n_r == 3'd1) begin
              p_nxt     = ONE_Q24 + 26'(prod_r[48:24]);
              state_nxt = S_EXPF;
            end else begin
              op_a_nxt = {38'd0, prod_r[48:24]};
              op_b_nxt = recip(n_r);
              op_nxt   = OP_HQ;
            end
          end
          OP_HQ: begin
            q_nxt     = prod_r[56:32];
            state_nxt = S_DIVC;
          end
          OP_Q: begin
            qv_nxt   = msh12;
            op_a_nxt = msh12;
            op_b_nxt = 32'(gmag_r);
            op_nxt   = OP_TE;
          end
          OP_TE: begin
            te_nxt   = msh8;
            op_a_nxt = qv_r;
            op_b_nxt = 32'(dmag_r);
            op_nxt   = OP_T1;
          end
          OP_T1: begin
            op_a_nxt = msh12;
            op_b_nxt = 32'(wmag);
            op_nxt   = OP_T2;
          end
          OP_T2: begin
            op_a_nxt = msh12;
            op_b_nxt = 32'(gmag_r);
            op_nxt   = OP_TA;
          end
          OP_TA: begin
            ta_nxt    = msh8;
            state_nxt = S_WB;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DIVC: begin
        p_nxt     = ONE_Q24 + 26'(qc);
        n_nxt     = n_r - 3'd1;
        op_a_nxt  = {39'd0, r_r};
        op_b_nxt  = 32'(ONE_Q24 + 26'(qc));
        op_nxt    = OP_HV;
        state_nxt = S_MLO;
      end
      S_EXPF: begin
        op_a_nxt  = {47'd0, dmag_r};
        op_b_nxt  = e_v;
        op_nxt    = OP_Q;
        state_nxt = S_MLO;
      end
      S_WB: begin
        sat_nxt   = sat_r | ov_a | ov_e;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      op_r        <= OP_AD;
      clr_idx_r   <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      clr_idx_r   <= clr_idx_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    ok_r       <= ok_nxt;
    dmag_r     <= dmag_nxt;
    gmag_r     <= gmag_nxt;
    dneg_r     <= dneg_nxt;
    gneg_r     <= gneg_nxt;
    xneg_r     <= xneg_nxt;
    op_a_r     <= op_a_nxt;
    op_b_r     <= op_b_nxt;
    prod_r     <= prod_nxt;
    k_r        <= k_nxt;
    r_r        <= r_nxt;
    p_r        <= p_nxt;
    v_r        <= v_nxt;
    q_r        <= q_nxt;
    n_r        <= n_nxt;
    qv_r       <= qv_nxt;
    te_r       <= te_nxt;
    ta_r       <= ta_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (param_we) begin
      param_mem[row_in] <= {in_word.decay_param, in_word.embed_weight};
    end
    if (rd_en) begin
      param_q_r <= param_mem[row_in];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (rd_en) begin
      acc_q_r <= acc_mem[row_in];
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_strobe_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == S_READ)
    else $error("result strobe without a read");

  a_clear_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.cmd == CMD_CLEAR) |=> (!sat_r && state_r == S_CLEAR))
    else $error("clear did not reset flag or start sweep");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ok && in_word.cmd == CMD_ACC) |=> (busy && state_r == S_SETUP))
    else $error("accumulate did not start");
`endif

endmodule

`default_nettype wire

// File: dv/tb_exp_descriptor_gradient_accumulator.sv
`timescale 1ns / 100ps

import edga_pkg::*;

class edga_scoreboard;
  logic signed [15:0] decay_q[128];
  logic signed [15:0] weight_q[128];
  longint alpha_acc[128];
  longint embed_acc[128];
  bit sat_flag;
  edga_out_t read_q[$];
  int errors;

  function new();
    foreach (alpha_acc[i]) begin
      alpha_acc[i] = 0;
      embed_acc[i] = 0;
      decay_q[i] = '0;
      weight_q[i] = '0;
    end
    sat_flag = 0;
    errors = 0;
  endfunction

  function longint unsigned mul_round(longint unsigned a, longint unsigned b, int s);
    longint unsigned cap, p;
    cap = 64'd1 << 62;
    if (a != 0 && b > cap / a) return cap;
    p = (a * b + (64'd1 << (s - 1))) >> s;
    return (p > cap) ? cap : p;
  endfunction

  function longint unsigned exp_q16(longint a, longint d);
    longint x, y;
    logic [63:0] yb;
    longint unsigned yq, f, r, p;
    int k;
    x = a * d;
    y = x * 64'sd1549082005;
    yb = y + (64'sd1 <<< 61);
    yq = yb >> 30;
    k = int'(yq >> 24) - 128;
    f = yq & 64'hFF_FFFF;
    r = (f * 64'd11629080) >> 24;
    p = 64'd1 << 24;
    for (int n = 6; n >= 1; n--) p = (64'd1 << 24) + ((r * p) >> 24) / n;
    if (k >= 16) return 64'hFFFF_FFFF;
    if (k >= 8) return p << (k - 8);
    if (8 - k > 40) return 0;
    return p >> (8 - k);
  endfunction

  function longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function void sat_add(ref longint acc, input longint unsigned m, input bit neg);
    longint s;
    s = neg ? acc - longint'(m) : acc + longint'(m);
    if (s > 64'sd140737488355327) begin
      s = 64'sd140737488355327;
      sat_flag = 1;
    end else if (s < -64'sd140737488355328) begin
      s = -64'sd140737488355328;
      sat_flag = 1;
    end
    acc = s;
  endfunction

  function void note_input(edga_in_t w);
    int row;
    longint d, g, a, wt;
    longint unsigned e, q, te, t1, t2, ta;
    edga_out_t o;
    row = w.type_index * 16 + w.alpha_index;
    case (w.cmd)
      CMD_LOAD: begin
        decay_q[row] = w.decay_param;
        weight_q[row] = w.embed_weight;
      end
      CMD_ACC: begin
        d = longint'($signed(w.descriptor));
        g = longint'($signed(w.upstream_grad));
        a = longint'($signed(decay_q[row]));
        wt = longint'($signed(weight_q[row]));
        e = exp_q16(a, d);
        q = mul_round(magn(d), e, 12);
        te = mul_round(q, magn(g), 8);
        t1 = mul_round(q, magn(d), 12);
        t2 = mul_round(t1, magn(wt), 12);
        ta = mul_round(t2, magn(g), 8);
        sat_add(alpha_acc[row], ta, (wt < 0) != (g < 0));
        sat_add(embed_acc[row], te, (d < 0) != (g < 0));
      end
      CMD_READ: begin
        o.grad_alpha_sum = alpha_acc[row][47:0];
        o.grad_embed_sum = embed_acc[row][47:0];
        o.overflow = sat_flag;
        read_q.push_back(o);
      end
      CMD_CLEAR: begin
        foreach (alpha_acc[i]) begin
          alpha_acc[i] = 0;
          embed_acc[i] = 0;
        end
        sat_flag = 0;
      end
    endcase
  endfunction

  function void check(edga_out_t got);
    edga_out_t exp_w;
    if (read_q.size() == 0) begin
      $error("unexpected result word %h", got);
      errors++;
      return;
    end
    exp_w = read_q.pop_front();
    if (got.grad_alpha_sum !== exp_w.grad_alpha_sum) begin
      $error("grad_alpha_sum exp %h got %h", exp_w.grad_alpha_sum, got.grad_alpha_sum);
      errors++;
    end
    if (got.grad_embed_sum !== exp_w.grad_embed_sum) begin
      $error("grad_embed_sum exp %h got %h", exp_w.grad_embed_sum, got.grad_embed_sum);
      errors++;
    end
    if (got.overflow !== exp_w.overflow) begin
      $error("overflow exp %b got %b", exp_w.overflow, got.overflow);
      errors++;
    end
  endfunction
endclass

module tb_exp_descriptor_gradient_accumulator;
  logic clk;
  logic rst_n;
  logic start;
  edga_in_t in_word;
  logic busy;
  logic out_valid;
  edga_out_t out_word;

  edga_scoreboard sb;
  bit loaded[128];
  int idle_pct;
  int hot[4];

  exp_descriptor_gradient_accumulator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word),
    .busy(busy), .out_valid(out_valid), .out_word(out_word)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_word);
  end

  task automatic send(edga_in_t w);
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    sb.note_input(w);
    if (w.cmd == CMD_LOAD) loaded[w.type_index * 16 + w.alpha_index] = 1;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.read_q.size() != 0) @(posedge clk);
  endtask

  function automatic edga_in_t mk(logic [1:0] c, int row, logic [15:0] d, logic [23:0] g,
                                  logic [15:0] a, logic [15:0] w);
    edga_in_t x;
    x.cmd = c;
    x.type_index = row[6:4];
    x.alpha_index = row[3:0];
    x.descriptor = d;
    x.upstream_grad = g;
    x.decay_param = a;
    x.embed_weight = w;
    return x;
  endfunction

  function automatic logic [15:0] rnd16();
    int s;
    s = $urandom_range(0, 9);
    if (s < 4) return 16'($urandom);
    if (s < 9) return 16'($urandom_range(0, 8192) - 4096);
    return s[0] ? 16'h7FFF : 16'h8000;
  endfunction

  function automatic logic [23:0] rnd24();
    if ($urandom_range(0, 2) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 131072) - 65536);
  endfunction

  task automatic random_item();
    int row, c;
    edga_in_t w;
    row = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 3)] : $urandom_range(0, 127);
    c = $urandom_range(0, 99);
    if (c < 10) w = mk(CMD_LOAD, row, rnd16(), rnd24(), rnd16(), rnd16());
    else if (c < 65) begin
      if (loaded[row]) w = mk(CMD_ACC, row, rnd16(), rnd24(), rnd16(), rnd16());
      else w = mk(CMD_LOAD, row, rnd16(), rnd24(), rnd16(), rnd16());
    end else if (c < 97) w = mk(CMD_READ, row, rnd16(), rnd24(), rnd16(), rnd16());
    else w = mk(CMD_CLEAR, row, rnd16(), rnd24(), rnd16(), rnd16());
    send(w);
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    start = 0;
    in_word = '0;
    idle_pct = 0;
    foreach (hot[i]) hot[i] = $urandom_range(0, 127);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send(mk(CMD_READ, 127, 0, 0, 0, 0));
    send(mk(CMD_LOAD, 0, 0, 0, 16'h7FFF, 16'h8000));
    send(mk(CMD_LOAD, 127, 0, 0, 16'h8000, 16'h7FFF));
    send(mk(CMD_LOAD, 5, 0, 0, 16'h0000, 16'h1000));
    send(mk(CMD_ACC, 0, 16'h7FFF, 24'h800000, 0, 0));
    send(mk(CMD_ACC, 0, 16'h7FFF, 24'h7FFFFF, 0, 0));
    send(mk(CMD_ACC, 0, 16'h0000, 24'h7FFFFF, 0, 0));
    send(mk(CMD_READ, 0, 0, 0, 0, 0));
    send(mk(CMD_ACC, 127, 16'h8000, 24'h7FFFFF, 0, 0));
    send(mk(CMD_ACC, 127, 16'h7FFF, 24'h000001, 0, 0));
    send(mk(CMD_ACC, 5, 16'h1000, 24'h010000, 0, 0));
    send(mk(CMD_ACC, 5, 16'hF000, 24'hFF0000, 0, 0));
    send(mk(CMD_READ, 127, 0, 0, 0, 0));
    send(mk(CMD_READ, 5, 0, 0, 0, 0));
    for (int i = 0; i < 3; i++) send(mk(CMD_ACC, 0, 16'h7FFF, 24'h7FFFFF, 0, 0));
    send(mk(CMD_READ, 0, 0, 0, 0, 0));
    send(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 5, 0, 0, 0, 0));
    drain();

    idle_pct = 26;
    repeat (170) random_item();
    drain();
    idle_pct = 57;
    repeat (170) random_item();
    drain();
    idle_pct = 0;
    repeat (170) random_item();
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
